// ----- rtl/core/pce_pkg.sv -----
package pce_pkg;

   localparam int NUM_TERMS_DEFAULT = 32;
   localparam int COEF_W            = 32;

   typedef enum logic [2:0] {
      REQ_SET   = 3'd0,
      REQ_ADD   = 3'd1,
      REQ_CLEAR = 3'd2,
      REQ_EVAL  = 3'd3,
      REQ_DERIV = 3'd4
   } pce_op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   typedef struct packed {
      logic [2:0]               req_type;
      logic [5:0]               exponent;
      logic signed [COEF_W-1:0] coefficient;
      logic signed [COEF_W-1:0] point_x;
   } pce_req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] result_value;
      logic [4:0]               result_exponent;
      logic [1:0]               status;
      logic                     last;
   } pce_rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] value;
      logic                     sat;
   } pce_sat_type;

   // Clamp to the signed 32-bit range and flag the clamp.
   function automatic pce_sat_type sat32(input logic signed [63:0] v);
      pce_sat_type r;
      if (v > 64'sh000000007FFFFFFF) begin
         r.value = 32'sh7FFFFFFF;
         r.sat   = 1'b1;
      end else if (v < 64'shFFFFFFFF80000000) begin
         r.value = 32'sh80000000;
         r.sat   = 1'b1;
      end else begin
         r.value = v[31:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/pce_ram.sv -----
module pce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/polynomial_coeff_store_evaluator.sv -----
// Channel  Direction  Payload        Handshake
// req      in         pce_req_type   req_valid / req_stall
// rsp      out        pce_rsp_type   rsp_valid / rsp_stall
//
// One request at a time. Evaluate makes one coefficient table read, multiply and
// round-add per term through the single table read port. Derivative readout
// emits one item per nonconstant term, each through the output register.
// Synchronous reset empties the table at once (per-entry valid bits).
// A stalled result holds in the output register; the next request is taken meanwhile.
module polynomial_coeff_store_evaluator
   import pce_pkg::*;
#(
   parameter int NUM_TERMS = NUM_TERMS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pce_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pce_rsp_type rsp_data
);

   localparam int IW = $clog2(NUM_TERMS);
   localparam logic [6:0]    NT7      = 7'(NUM_TERMS);
   localparam logic [IW-1:0] IDX_TOP  = IW'(NUM_TERMS - 1);
   localparam logic [IW-1:0] IDX_NEXT = IW'(NUM_TERMS - 2);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_ADD_RD  = 7'b0000010,
      S_EV_LOAD = 7'b0000100,
      S_EV_MUL  = 7'b0001000,
      S_EV_ADD  = 7'b0010000,
      S_DV_MUL  = 7'b0100000,
      S_OUT     = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [IW-1:0]         idx_ff, idx_in;
   pce_req_type           req_ff, req_in;
   logic signed [31:0]    acc_ff, acc_in;
   logic signed [63:0]    prod_ff, prod_in;
   logic                  sat_ff, sat_in;
   pce_rsp_type           res_ff, res_in;
   pce_rsp_type           rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [NUM_TERMS-1:0]  valid_ff, valid_in;

   logic                  accept;
   logic                  out_free;
   logic                  mem_wr, mem_rd;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic [31:0]           wr_data, rd_data;
   logic signed [31:0]    coef_data;
   logic signed [32:0]    add_sum;
   logic signed [47:0]    scaled;
   logic signed [49:0]    horner_sum;
   logic signed [IW+32:0] dprod;
   pce_sat_type           add_sat, ev_sat, dv_sat;

   pce_ram #(
      .WIDTH (32),
      .DEPTH (NUM_TERMS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mem_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Entries never written since reset or clear read as zero.
   assign coef_data = rd_vld_ff ? rd_data : 32'sd0;

   assign add_sum    = 33'(coef_data) + 33'(req_ff.coefficient);
   assign add_sat    = sat32(64'(add_sum));
   // floor((p + 2^15) / 2^16) is the shifted product plus its bit 15.
   assign scaled     = prod_ff[63:16];
   assign horner_sum = 50'(scaled) + 50'(coef_data) + {49'd0, prod_ff[15]};
   assign ev_sat     = sat32(64'(horner_sum));
   assign dprod      = $signed({1'b0, idx_ff}) * coef_data;
   assign dv_sat     = sat32(64'(dprod));

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      req_in       = req_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      sat_in       = sat_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_wr       = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      mem_rd       = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               res_in = '{result_value: '0, result_exponent: '0, status: ST_OK, last: 1'b1};
               case (req_data.req_type)
                  REQ_SET, REQ_ADD: begin
                     if ({1'b0, req_data.exponent} >= NT7) begin
                        res_in.status = ST_RANGE;
                        state_in      = S_OUT;
                     end else if (req_data.req_type == REQ_SET) begin
                        mem_wr   = 1'b1;
                        wr_addr  = req_data.exponent[IW-1:0];
                        wr_data  = req_data.coefficient;
                        valid_in[req_data.exponent[IW-1:0]] = 1'b1;
                        state_in = S_OUT;
                     end else begin
                        mem_rd   = 1'b1;
                        rd_addr  = req_data.exponent[IW-1:0];
                        state_in = S_ADD_RD;
                     end
                  end
                  REQ_CLEAR: begin
                     valid_in = '0;
                     state_in = S_OUT;
                  end
                  REQ_EVAL: begin
                     mem_rd   = 1'b1;
                     rd_addr  = IDX_TOP;
                     sat_in   = 1'b0;
                     state_in = S_EV_LOAD;
                  end
                  REQ_DERIV: begin
                     mem_rd   = 1'b1;
                     rd_addr  = IW'(1);
                     idx_in   = IW'(1);
                     state_in = S_DV_MUL;
                  end
                  default: begin
                     // unused codes: drop the transaction
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            mem_wr   = 1'b1;
            wr_addr  = req_ff.exponent[IW-1:0];
            wr_data  = add_sat.value;
            valid_in[req_ff.exponent[IW-1:0]] = 1'b1;
            res_in.status = add_sat.sat ? ST_SAT : ST_OK;
            state_in = S_OUT;
         end
         S_EV_LOAD: begin
            acc_in   = coef_data;
            idx_in   = IDX_NEXT;
            mem_rd   = 1'b1;
            rd_addr  = IDX_NEXT;
            state_in = S_EV_MUL;
         end
         S_EV_MUL: begin
            prod_in  = acc_ff * req_ff.point_x;
            state_in = S_EV_ADD;
         end
         S_EV_ADD: begin
            acc_in = ev_sat.value;
            sat_in = sat_ff | ev_sat.sat;
            if (idx_ff == '0) begin
               res_in.result_value = ev_sat.value;
               res_in.status       = (sat_ff | ev_sat.sat) ? ST_SAT : ST_OK;
               state_in            = S_OUT;
            end else begin
               idx_in   = idx_ff - 1'b1;
               mem_rd   = 1'b1;
               rd_addr  = idx_ff - 1'b1;
               state_in = S_EV_MUL;
            end
         end
         S_DV_MUL: begin
            res_in.result_value    = dv_sat.value;
            res_in.result_exponent = 5'(idx_ff - 1'b1);
            res_in.status          = dv_sat.sat ? ST_SAT : ST_OK;
            res_in.last            = (idx_ff == IDX_TOP);
            state_in               = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               if (res_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  // advance the derivative walk
                  idx_in   = idx_ff + 1'b1;
                  mem_rd   = 1'b1;
                  rd_addr  = idx_ff + 1'b1;
                  state_in = S_DV_MUL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_vld_in = rd_vld_ff;
      if (mem_rd) begin
         rd_vld_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      req_ff  <= req_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      sat_ff  <= sat_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_write_window: assert property (@(posedge clock) disable iff (reset)
      mem_wr |-> (state_ff == S_IDLE || state_ff == S_ADD_RD))
      else $error("table written outside set or add");

   a_read_range: assert property (@(posedge clock) disable iff (reset)
      mem_rd |-> (rd_addr <= IDX_TOP))
      else $error("table read beyond last term");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_valid_ff && rsp_ff == $past(res_ff)))
      else $error("pending result not loaded into output register");

   a_horner_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EV_ADD && idx_ff != '0) |=>
         (state_ff == S_EV_MUL && idx_ff == $past(idx_ff) - 1'b1))
      else $error("evaluation index did not step down");

endmodule

// ----- bench/polynomial_coeff_store_evaluator_tb.sv -----
`timescale 1ns / 1ps

module polynomial_coeff_store_evaluator_tb;
   import pce_pkg::*;

   localparam int NUM_TERMS = NUM_TERMS_DEFAULT;
   localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;
   localparam int MAX_REPORTS = 10;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   pce_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pce_rsp_type rsp_data;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_left = 0;
   int fail_count    = 0;

   logic signed [31:0] coef_table [NUM_TERMS];
   pce_rsp_type        poly_results_due [$];

   polynomial_coeff_store_evaluator #(
      .NUM_TERMS(NUM_TERMS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      coef_table = '{default: '0};
   end

   // Result-side stall: a forced hold-off takes priority over random stalls.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Bit 32 flags saturation, bits 31:0 hold the clamped value.
   function automatic logic [32:0] clamp_q16(input logic signed [63:0] v);
      if (v > 64'sh7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
      if (v < -64'sh80000000) return {1'b1, 32'h80000000};
      return {1'b0, v[31:0]};
   endfunction

   function automatic void compute_poly_response(input pce_req_type r);
      pce_rsp_type        rsp;
      logic signed [31:0] acc;
      logic signed [31:0] x;
      logic signed [31:0] c;
      logic signed [63:0] prod;
      logic [32:0]        clamped;
      logic               any_sat;
      rsp      = '0;
      rsp.last = 1'b1;
      x        = r.point_x;
      c        = r.coefficient;
      any_sat  = 1'b0;
      case (r.req_type)
         REQ_SET, REQ_ADD: begin
            if (r.exponent >= NUM_TERMS) begin
               rsp.status = ST_RANGE;
            end else if (r.req_type == REQ_SET) begin
               coef_table[r.exponent] = c;
            end else begin
               prod    = coef_table[r.exponent];
               prod    = prod + c;
               clamped = clamp_q16(prod);
               coef_table[r.exponent] = clamped[31:0];
               rsp.status = clamped[32] ? ST_SAT : ST_OK;
            end
            poly_results_due.push_back(rsp);
         end
         REQ_CLEAR: begin
            foreach (coef_table[i]) coef_table[i] = '0;
            poly_results_due.push_back(rsp);
         end
         REQ_EVAL: begin
            acc = coef_table[NUM_TERMS-1];
            for (int i = NUM_TERMS - 2; i >= 0; i--) begin
               prod    = acc * x;
               // round to nearest, ties toward plus infinity
               prod    = (prod + 64'sd32768) >>> 16;
               prod    = prod + coef_table[i];
               clamped = clamp_q16(prod);
               acc     = clamped[31:0];
               any_sat = any_sat | clamped[32];
            end
            rsp.result_value = acc;
            rsp.status       = any_sat ? ST_SAT : ST_OK;
            poly_results_due.push_back(rsp);
         end
         REQ_DERIV: begin
            for (int i = 1; i < NUM_TERMS; i++) begin
               prod    = coef_table[i];
               prod    = prod * i;
               clamped = clamp_q16(prod);
               rsp.result_value    = clamped[31:0];
               rsp.result_exponent = 5'(i - 1);
               rsp.status          = clamped[32] ? ST_SAT : ST_OK;
               rsp.last            = (i == NUM_TERMS - 1);
               poly_results_due.push_back(rsp);
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : rsp_check
      pce_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (poly_results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result transaction: %p", rsp_data);
         end else begin
            want = poly_results_due.pop_front();
            if (rsp_data.result_value !== want.result_value ||
                rsp_data.result_exponent !== want.result_exponent ||
                rsp_data.status !== want.status ||
                rsp_data.last !== want.last) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("mismatch: value exp %h got %h, exponent exp %0d got %0d,",
                           want.result_value, rsp_data.result_value,
                           want.result_exponent, rsp_data.result_exponent);
                  $display("          status exp %0d got %0d, last exp %0b got %0b",
                           want.status, rsp_data.status, want.last, rsp_data.last);
               end
            end
         end
      end
   end

   function automatic pce_req_type make_request(input logic [2:0] op, input logic [5:0] e,
                                                input logic [31:0] c, input logic [31:0] x);
      pce_req_type r;
      r.req_type    = op;
      r.exponent    = e;
      r.coefficient = c;
      r.point_x     = x;
      return r;
   endfunction

   function automatic logic [31:0] random_q16();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(32'h1FFFF)) - 32'h10000;
         2: return 32'($urandom_range(32'h1FFFFFF)) - 32'h1000000;
         default: begin
            case ($urandom_range(3))
               0: return 32'h7FFFFFFF;
               1: return 32'h80000000;
               2: return 32'hFFFFFFFF;
               default: return 32'h0;
            endcase
         end
      endcase
   endfunction

   // Keep |x| small most of the time so long polynomials stay in range.
   function automatic logic [31:0] random_point();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return 32'($urandom_range(32'h1FFFF)) - 32'h10000;
      if (sel < 85) return 32'($urandom_range(32'h7FFFF)) - 32'h40000;
      return $urandom;
   endfunction

   function automatic pce_req_type random_request();
      pce_req_type r;
      int          sel;
      sel = $urandom_range(99);
      if (sel < 35)      r.req_type = REQ_SET;
      else if (sel < 55) r.req_type = REQ_ADD;
      else if (sel < 60) r.req_type = REQ_CLEAR;
      else if (sel < 80) r.req_type = REQ_EVAL;
      else if (sel < 90) r.req_type = REQ_DERIV;
      else r.req_type = 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
      if ($urandom_range(99) < 85) r.exponent = 6'($urandom_range(NUM_TERMS - 1));
      else r.exponent = 6'($urandom_range(63, NUM_TERMS));
      r.coefficient = random_q16();
      r.point_x     = random_point();
      return r;
   endfunction

   task automatic send_request(input pce_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      compute_poly_response(r);
   endtask

   // Drop valid and hold until every outstanding result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (poly_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(make_request(REQ_CLEAR, '0, '0, '0));
      send_request(make_request(REQ_SET, '0, 32'h7FFFFFFF, '0));
      send_request(make_request(REQ_ADD, '0, 32'h00000001, '0));
      send_request(make_request(REQ_SET, 6'(NUM_TERMS - 1), 32'h80000000, '0));
      send_request(make_request(REQ_ADD, 6'(NUM_TERMS - 1), 32'hFFFFFFFF, '0));
      send_request(make_request(REQ_SET, 6'(NUM_TERMS), 32'h12345678, '0));
      send_request(make_request(REQ_ADD, '1, '1, '1));
      send_request(make_request(REQ_DERIV, '0, '0, '0));
      send_request(make_request(REQ_EVAL, '0, '0, 32'h7FFFFFFF));
      send_request(make_request(REQ_EVAL, '0, '0, 32'h80000000));
      send_request(make_request(REQ_CLEAR, '0, '0, '0));
      // half-LSB products: positive tie rounds up, negative tie rounds to zero
      send_request(make_request(REQ_SET, 6'd1, 32'h00000001, '0));
      send_request(make_request(REQ_EVAL, '0, '0, 32'h00008000));
      send_request(make_request(REQ_SET, 6'd1, 32'hFFFFFFFF, '0));
      send_request(make_request(REQ_EVAL, '0, '0, 32'h00008000));
      send_request(make_request(REQ_SET, 6'(NUM_TERMS - 2), 32'h00010000, '0));
      send_request(make_request(REQ_ADD, 6'd2, 32'hFFFF0000, '0));
      send_request(make_request(REQ_DERIV, '0, '0, '0));
      send_request(make_request(REQ_EVAL, '0, '0, '0));
      send_request(make_request(REQ_EVAL, '0, '0, 32'hFFFF0000));
      send_request(make_request(REQ_FIRST_UNUSED, '1, '1, '1));
      send_request(make_request(REQ_LAST_UNUSED, '0, '0, '0));
      send_request(make_request(REQ_CLEAR, '0, '0, '0));
      send_request(make_request(REQ_EVAL, '0, '0, 32'h7FFFFFFF));
      send_request(make_request(REQ_DERIV, '0, '0, '0));
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      pce_req_type r;
      int          sent;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < count) begin
         r = random_request();
         send_request(r);
         if (r.req_type < REQ_FIRST_UNUSED) sent++;
      end
      wait_for_results();
   endtask

   // Block the result side long enough for the block to fill and stall requests.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_left <= 300;
      repeat (20) send_request(random_request());
      wait_for_results();
   endtask

   task automatic test_drain_pause();
      send_idle_pct = 0;
      rsp_stall_pct = 19;
      repeat (10) send_request(random_request());
      wait_for_results();
      repeat (10) send_request(random_request());
      wait_for_results();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(20, 0, 0);
      test_random_traffic(20, 46, 0);
      test_random_traffic(20, 0, 46);
      test_random_traffic(20, 19, 19);
      test_output_backpressure();
      test_drain_pause();
      repeat (4 * NUM_TERMS) @(posedge clock);
      fail_count += poly_results_due.size();
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
